// File: rtl/cdt_pkg.sv
// Shared constants, register indexes and types of the clocked CFD trigger.
package cdt_pkg;

    // Delay limits and history depth
    localparam int MAX_CFD_DELAY  = 16;
    localparam int MAX_TRIG_DELAY = 16;
    localparam int HIST_DEPTH     = MAX_CFD_DELAY + MAX_TRIG_DELAY;
    localparam int HIST_IDX_W     = $clog2(HIST_DEPTH);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 12;
    localparam int BIN_W    = 12;
    localparam int DELAY_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Highest bin index that is still scanned
    localparam logic [BIN_W-1:0] LAST_BIN = {BIN_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CROSS_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRACTION_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_BIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CFD_DELAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_DELAY   = 3'd5;

    // Register reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET       = 12'd256;
    localparam logic [DELAY_W-1:0] CFD_DELAY_RESET  = 5'd4;
    localparam logic [DELAY_W-1:0] TRIG_DELAY_RESET = 5'd3;

    // Configuration as seen by the datapath, delays already clamped
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] threshold;
        logic signed [SAMPLE_W-1:0] cross_offset;
        logic [GAIN_W-1:0]          fraction_gain;
        logic [BIN_W-1:0]           start_bin;
        logic [DELAY_W-1:0]         cfd_delay;
        logic [DELAY_W-1:0]         trig_delay;
    } t_cfg;

endpackage

// File: rtl/clocked_cfd_trigger_top.sv
// Top level of the clocked constant-fraction trigger: history line, two-stage datapath, output.
//
// One waveform bin is taken per clock while results are taken. A transfer enters the
// input stage, where the sample history is shifted and the two delayed taps are
// picked; the evaluation stage then forms cfd = tap - floor(gain * older_tap / 256),
// tracks the armed flag and loads the output register as the bin leaves the input
// stage, and the block sustains one bin per cycle while results are taken. The only
// back-pressure comes from the output register: while a result waits there untaken,
// the input stage holds and input ready drops. Each waveform gives at most one result:
// the first bin whose falling crossing is confirmed by its own sample reaching the
// threshold, or a not-found result on the bin marked last; a waveform with no last
// mark and no confirmed crossing gives none. Configuration writes are always
// accepted and must only be made while the block is drained.
module clocked_cfd_trigger_top
    import cdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_first,
    input  logic                  i_last,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_triggered,
    output logic [BIN_W-1:0]      o_trigger_bin,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg w_cfg;

    cdt_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Input stage: history line and tap selection
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0] r_hist [HIST_DEPTH];
    logic                r_s1_valid;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic signed [SAMPLE_W-1:0] r_s1_tap_now;
    logic signed [SAMPLE_W-1:0] r_s1_tap_old;
    logic                r_s1_first;
    logic                r_s1_last;

    logic                w_in_xfer;
    logic                w_adv;
    logic [SAMPLE_W-1:0] w_tap_now;
    logic [SAMPLE_W-1:0] w_tap_old;
    logic [DELAY_W:0]    w_old_lag;
    logic [HIST_IDX_W-1:0] w_now_idx;
    logic [HIST_IDX_W-1:0] w_old_idx;

    assign w_adv      = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || w_adv;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // Pick the taps at lag trig_delay and trig_delay + cfd_delay
    assign w_old_lag = {1'b0, w_cfg.trig_delay} + {1'b0, w_cfg.cfd_delay} - (DELAY_W+1)'(1);
    assign w_old_idx = w_old_lag[HIST_IDX_W-1:0];
    assign w_now_idx = HIST_IDX_W'(w_cfg.trig_delay - DELAY_W'(1));
    assign w_tap_old = r_hist[w_old_idx];
    assign w_tap_now = (w_cfg.trig_delay == '0) ? i_sample : r_hist[w_now_idx];

    // Shift the history on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_hist[k] <= '0;
            end
        end else if (w_in_xfer) begin
            r_hist[0] <= i_sample;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_hist[k] <= r_hist[k-1];
            end
        end
    end

    // Hold the transferred bin and its taps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_sample  <= i_sample;
            r_s1_tap_now <= w_tap_now;
            r_s1_tap_old <= w_tap_old;
            r_s1_first   <= i_first;
            r_s1_last    <= i_last;
        end
    end

    // ---------------------------------------------------------------
    // Evaluation stage: CFD value, crossing tracking, result
    // ---------------------------------------------------------------
    logic [BIN_W-1:0] r_bin;
    logic             r_fired;
    logic             r_done;
    logic             r_over;
    logic [BIN_W-1:0] n_bin;
    logic             n_fired;
    logic             n_done;
    logic             n_over;

    logic [BIN_W-1:0] w_bin;
    logic             w_fired;
    logic             w_done;
    logic             w_over;
    logic [BIN_W-1:0] w_istart;
    logic [BIN_W:0]   w_scan_from;
    logic signed [SAMPLE_W+GAIN_W:0] w_prod;
    logic signed [SAMPLE_W+GAIN_W-8:0] w_quot;
    logic signed [SAMPLE_W+GAIN_W-8:0] w_cfd;
    logic signed [SAMPLE_W+GAIN_W-8:0] w_level;
    logic             w_emit;
    logic             w_hit;

    // Restart the waveform state on the first mark
    always_comb begin
        if (r_s1_first) begin
            w_bin   = '0;
            w_fired = 1'b0;
            w_done  = 1'b0;
            w_over  = 1'b0;
        end else begin
            w_bin   = r_bin;
            w_fired = r_fired;
            w_done  = r_done;
            w_over  = r_over;
        end
    end

    // Form the CFD value; the shift floors the scaled product
    assign w_prod  = r_s1_tap_old * $signed({1'b0, w_cfg.fraction_gain});
    assign w_quot  = w_prod[SAMPLE_W+GAIN_W:8];
    assign w_cfd   = (SAMPLE_W+GAIN_W-7)'(r_s1_tap_now) - w_quot;
    assign w_level = (SAMPLE_W+GAIN_W-7)'(w_cfg.cross_offset);

    assign w_istart = (w_cfg.start_bin > BIN_W'(w_cfg.cfd_delay))
                    ? w_cfg.start_bin : BIN_W'(w_cfg.cfd_delay);
    assign w_scan_from = {1'b0, w_istart} + (BIN_W+1)'(w_cfg.trig_delay);

    // Track crossings and decide the result
    always_comb begin
        n_fired = w_fired;
        n_done  = w_done;
        w_emit  = 1'b0;
        w_hit   = 1'b0;
        if (!w_done) begin
            if (r_s1_last) begin
                w_emit = 1'b1;
                n_done = 1'b1;
            end else if (!w_over && ({1'b0, w_bin} >= w_scan_from)) begin
                if ({1'b0, w_bin} == w_scan_from) begin
                    n_fired = (w_cfd < w_level);
                end else if (w_fired) begin
                    if (w_cfd > w_level) begin
                        n_fired = 1'b0;
                    end
                end else if (w_cfd <= w_level) begin
                    if (r_s1_sample >= w_cfg.threshold) begin
                        w_emit = 1'b1;
                        w_hit  = 1'b1;
                        n_done = 1'b1;
                    end
                    n_fired = 1'b1;
                end
            end
        end
    end

    // Advance the bin counter until it saturates
    always_comb begin
        n_bin  = w_bin;
        n_over = w_over;
        if (!w_over) begin
            if (w_bin != LAST_BIN) begin
                n_bin = w_bin + BIN_W'(1);
            end else begin
                n_over = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin   <= '0;
            r_fired <= 1'b0;
            r_done  <= 1'b0;
            r_over  <= 1'b0;
        end else if (w_adv) begin
            r_bin   <= n_bin;
            r_fired <= n_fired;
            r_done  <= n_done;
            r_over  <= n_over;
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic             r_out_valid;
    logic             r_out_trig;
    logic [BIN_W-1:0] r_out_bin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_out_trig <= w_hit;
            r_out_bin  <= w_hit ? w_bin : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_triggered   = r_out_trig;
    assign o_trigger_bin = r_out_bin;

endmodule

// File: rtl/cdt_cfg_regs.sv
// Configuration register bank of the clocked CFD trigger, with delay clamping.
module cdt_cfg_regs
    import cdt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    logic signed [SAMPLE_W-1:0] r_threshold;
    logic signed [SAMPLE_W-1:0] r_cross_offset;
    logic [GAIN_W-1:0]          r_fraction_gain;
    logic [BIN_W-1:0]           r_start_bin;
    logic [DELAY_W-1:0]         r_cfd_delay;
    logic [DELAY_W-1:0]         r_trig_delay;

    // Write the addressed register on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= '0;
            r_cross_offset  <= '0;
            r_fraction_gain <= GAIN_RESET;
            r_start_bin     <= '0;
            r_cfd_delay     <= CFD_DELAY_RESET;
            r_trig_delay    <= TRIG_DELAY_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD:     r_threshold     <= i_cfg_data;
                CFG_CROSS_OFFSET:  r_cross_offset  <= i_cfg_data;
                CFG_FRACTION_GAIN: r_fraction_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_START_BIN:     r_start_bin     <= i_cfg_data[BIN_W-1:0];
                CFG_CFD_DELAY:     r_cfd_delay     <= i_cfg_data[DELAY_W-1:0];
                CFG_TRIG_DELAY:    r_trig_delay    <= i_cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp delays into their legal ranges
    always_comb begin
        o_cfg.threshold     = r_threshold;
        o_cfg.cross_offset  = r_cross_offset;
        o_cfg.fraction_gain = r_fraction_gain;
        o_cfg.start_bin     = r_start_bin;
        if (r_cfd_delay == '0) begin
            o_cfg.cfd_delay = DELAY_W'(1);
        end else if (r_cfd_delay > DELAY_W'(MAX_CFD_DELAY)) begin
            o_cfg.cfd_delay = DELAY_W'(MAX_CFD_DELAY);
        end else begin
            o_cfg.cfd_delay = r_cfd_delay;
        end
        if (r_trig_delay > DELAY_W'(MAX_TRIG_DELAY)) begin
            o_cfg.trig_delay = DELAY_W'(MAX_TRIG_DELAY);
        end else begin
            o_cfg.trig_delay = r_trig_delay;
        end
    end

endmodule
